>>> sv/afd_pkg.sv
// ----------------------------------------------------------------------------
// afd_pkg
// Shared types and constants for the authentication frame decoder.
// ----------------------------------------------------------------------------
package afd_pkg;

   localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

   localparam int unsigned LEN_W      = 10;
   localparam int unsigned INDEX_W    = 9;
   localparam int unsigned MAX_LEN_BYTES = 10;

   localparam logic [1:0] KIND_REQUEST  = 2'd0;
   localparam logic [1:0] KIND_ACCEPTED = 2'd1;
   localparam logic [1:0] KIND_REJECTED = 2'd2;

   localparam logic OUT_BODY    = 1'b0;
   localparam logic OUT_VERDICT = 1'b1;

   // register indexes on the configuration port
   localparam logic [2:0] REG_TAG_REQUEST  = 3'd0;
   localparam logic [2:0] REG_TAG_REPLY    = 3'd1;
   localparam logic [2:0] REG_CODE_ACCEPT  = 3'd2;
   localparam logic [2:0] REG_CODE_REJECT  = 3'd3;
   localparam logic [2:0] REG_MAX_ID_LEN   = 3'd4;
   localparam logic [2:0] REG_MAX_RSN_LEN  = 3'd5;

   typedef struct packed {
      logic [7:0] tag_request;
      logic [7:0] tag_reply;
      logic [7:0] code_accepted;
      logic [7:0] code_rejected;
      logic [7:0] max_id_length;
      logic [8:0] max_reason_length;
   } afd_cfg_type;

   // results caused by one input byte: an optional body byte and an
   // optional verdict, sharing kind and length
   typedef struct packed {
      logic               body_valid;
      logic [7:0]         body_byte;
      logic [INDEX_W-1:0] body_index;
      logic               verdict_valid;
      logic               frame_ok;
      logic [1:0]         message_kind;
      logic [LEN_W-1:0]   declared_length;
   } afd_entry_type;

endpackage

>>> sv/auth_frame_decoder.sv
// ----------------------------------------------------------------------------
// auth_frame_decoder
// Byte-serial parser for tagged, LEB128 length-prefixed frames.
// ----------------------------------------------------------------------------
// Takes one frame byte per transfer on req_ (tlast ends a frame) and gives
// body bytes with their index and one verdict per frame on rsp_. The parser
// accepts a byte every cycle while the result queue (QueueDepth entries) has
// room; a byte that yields both a body byte and the verdict gives two results
// in turn, so sustained rate is one byte per cycle except at frame ends, where
// the single-result-per-cycle output register sets the pace, and while
// rsp_tready is low. Each result passes the queue and then the output register.
// Registers sit at byte addresses 0x00..0x14 of the csr_ port; the user must
// write them only while the block is idle, which the block does not enforce.
// ----------------------------------------------------------------------------
module auth_frame_decoder
   import afd_pkg::*;
#(
   parameter int unsigned QueueDepth = QUEUE_DEPTH_DEFAULT
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // in_byte
   input  logic        req_tlast,   // last_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [7:0] body_byte, [16:8] body_index,
                                    // [18:17] message_kind, [19] frame_ok,
                                    // [29:20] declared_length, [31:30] zero
   output logic        rsp_tuser,   // out_kind
   output logic        rsp_tlast,   // last_result
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   afd_cfg_type   cfg_ff;
   logic [2:0]    reg_sel;
   logic          wr_en;
   logic          queue_full, push, pop, head_valid;
   afd_entry_type push_entry, head_entry;

   assign csr_pready = 1'b1;
   assign reg_sel    = csr_paddr[4:2];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tag_request       <= 8'd1;
         cfg_ff.tag_reply         <= 8'd2;
         cfg_ff.code_accepted     <= 8'd1;
         cfg_ff.code_rejected     <= 8'd0;
         cfg_ff.max_id_length     <= 8'd128;
         cfg_ff.max_reason_length <= 9'd256;
      end else if (wr_en) begin
         case (reg_sel)
            REG_TAG_REQUEST: cfg_ff.tag_request       <= csr_pwdata[7:0];
            REG_TAG_REPLY:   cfg_ff.tag_reply         <= csr_pwdata[7:0];
            REG_CODE_ACCEPT: cfg_ff.code_accepted     <= csr_pwdata[7:0];
            REG_CODE_REJECT: cfg_ff.code_rejected     <= csr_pwdata[7:0];
            REG_MAX_ID_LEN:  cfg_ff.max_id_length     <= csr_pwdata[7:0];
            REG_MAX_RSN_LEN: cfg_ff.max_reason_length <= csr_pwdata[8:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_TAG_REQUEST: csr_prdata = {24'd0, cfg_ff.tag_request};
         REG_TAG_REPLY:   csr_prdata = {24'd0, cfg_ff.tag_reply};
         REG_CODE_ACCEPT: csr_prdata = {24'd0, cfg_ff.code_accepted};
         REG_CODE_REJECT: csr_prdata = {24'd0, cfg_ff.code_rejected};
         REG_MAX_ID_LEN:  csr_prdata = {24'd0, cfg_ff.max_id_length};
         REG_MAX_RSN_LEN: csr_prdata = {23'd0, cfg_ff.max_reason_length};
         default:         csr_prdata = 32'd0;
      endcase
   end

   afd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .queue_full (queue_full),
      .push       (push),
      .push_entry (push_entry)
   );

   afd_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   afd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

>>> sv/afd_front.sv
// ----------------------------------------------------------------------------
// afd_front
// Byte parser: tracks the frame phase, decodes the LEB128 length and
// pushes the results of each byte into the result queue.
// ----------------------------------------------------------------------------
module afd_front
   import afd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  afd_cfg_type   cfg,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [7:0]    req_tdata,
   input  logic          req_tlast,
   input  logic          queue_full,
   output logic          push,
   output afd_entry_type push_entry
);

   typedef enum logic [2:0] {
      PH_TAG, PH_FLAG, PH_LEN, PH_BODY, PH_DONE, PH_SKIP
   } phase_type;

   phase_type        phase_ff, phase_in;
   logic [1:0]       kind_ff, kind_in;
   logic [3:0]       shift_ff, shift_in;
   logic [LEN_W-1:0] len_lo_ff, len_lo_in;   // low bits of the length
   logic             len_hi_ff, len_hi_in;   // any bit at or above LEN_W set
   logic [LEN_W-1:0] count_ff, count_in;

   logic             accept;
   logic [7:0]       b;
   logic [9:0]       limit;
   logic             emit_body;
   logic             ok;

   assign req_tready = ~queue_full;
   assign accept     = req_tvalid & req_tready;
   assign b          = req_tdata;

   always_comb begin
      phase_in  = phase_ff;
      kind_in   = kind_ff;
      shift_in  = shift_ff;
      len_lo_in = len_lo_ff;
      len_hi_in = len_hi_ff;
      count_in  = count_ff;
      emit_body = 1'b0;
      limit     = 10'd0;
      ok        = 1'b0;

      case (phase_ff)
         PH_TAG: begin
            if (b == cfg.tag_request) begin
               kind_in  = KIND_REQUEST;
               phase_in = PH_LEN;
            end else if (b == cfg.tag_reply) begin
               kind_in  = KIND_ACCEPTED;
               phase_in = PH_FLAG;
            end else begin
               phase_in = PH_SKIP;
            end
         end
         PH_FLAG: begin
            if (b == cfg.code_accepted) begin
               kind_in  = KIND_ACCEPTED;
               phase_in = PH_DONE;
            end else if (b == cfg.code_rejected) begin
               kind_in  = KIND_REJECTED;
               phase_in = PH_LEN;
            end else begin
               phase_in = PH_SKIP;
            end
         end
         PH_LEN: begin
            if (shift_ff >= 4'(MAX_LEN_BYTES)) begin
               phase_in = PH_SKIP;
            end else begin
               // fold seven payload bits in; only the low ten are kept exact
               case (shift_ff)
                  4'd0: len_lo_in = len_lo_ff | {3'b000, b[6:0]};
                  4'd1: begin
                     len_lo_in = len_lo_ff | {b[2:0], 7'b0000000};
                     len_hi_in = len_hi_ff | (|b[6:3]);
                  end
                  4'd9:    len_hi_in = len_hi_ff | b[0];
                  default: len_hi_in = len_hi_ff | (|b[6:0]);
               endcase
               shift_in = shift_ff + 4'd1;
               if (!b[7]) begin
                  limit = (kind_ff == KIND_REQUEST) ? {2'b00, cfg.max_id_length}
                                                    : {1'b0, cfg.max_reason_length};
                  if (len_hi_in || len_lo_in > limit) begin
                     phase_in = PH_SKIP;
                  end else begin
                     count_in = '0;
                     phase_in = PH_BODY;
                  end
               end
            end
         end
         PH_BODY: begin
            if (len_hi_ff || count_ff < len_lo_ff) begin
               emit_body = 1'b1;
               count_in  = count_ff + 1'b1;
            end else begin
               phase_in = PH_SKIP;
            end
         end
         default: ;
      endcase

      ok = (phase_in == PH_DONE) ||
           (phase_in == PH_BODY && !len_hi_in && count_in == len_lo_in);

      push_entry.body_valid      = emit_body;
      push_entry.body_byte       = b;
      push_entry.body_index      = count_ff[INDEX_W-1:0];
      push_entry.verdict_valid   = req_tlast;
      push_entry.frame_ok        = ok;
      push_entry.message_kind    = kind_in;
      push_entry.declared_length = len_hi_in ? {LEN_W{1'b1}} : len_lo_in;

      // end of frame: back to the tag phase
      if (req_tlast) begin
         phase_in  = PH_TAG;
         kind_in   = KIND_REQUEST;
         shift_in  = '0;
         len_lo_in = '0;
         len_hi_in = 1'b0;
         count_in  = '0;
      end
   end

   assign push = accept & (emit_body | req_tlast);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_TAG;
         kind_ff   <= KIND_REQUEST;
         shift_ff  <= '0;
         len_lo_ff <= '0;
         len_hi_ff <= 1'b0;
         count_ff  <= '0;
      end else if (accept) begin
         phase_ff  <= phase_in;
         kind_ff   <= kind_in;
         shift_ff  <= shift_in;
         len_lo_ff <= len_lo_in;
         len_hi_ff <= len_hi_in;
         count_ff  <= count_in;
      end
   end

endmodule

>>> sv/afd_queue.sv
// ----------------------------------------------------------------------------
// afd_queue
// Small register queue between the parser and the result emitter.
// ----------------------------------------------------------------------------
module afd_queue
   import afd_pkg::*;
#(
   parameter int unsigned Depth = QUEUE_DEPTH_DEFAULT
)
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  afd_entry_type push_entry,
   output logic          full,
   input  logic          pop,
   output logic          head_valid,
   output afd_entry_type head_entry
);

   localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int unsigned CntW = $clog2(Depth + 1);

   afd_entry_type     slot_ff [Depth];
   logic [PtrW-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CntW-1:0]   count_ff;
   logic              do_push, do_pop;

   assign full       = (count_ff == CntW'(Depth));
   assign head_valid = (count_ff != '0);
   assign head_entry = slot_ff[rd_ptr_ff];
   assign do_push    = push & ~full;
   assign do_pop     = pop & head_valid;

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         case ({do_push, do_pop})
            2'b10:   count_ff <= count_ff + 1'b1;
            2'b01:   count_ff <= count_ff - 1'b1;
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

>>> sv/afd_back.sv
// ----------------------------------------------------------------------------
// afd_back
// Result emitter: splits each queue entry into its body-byte and verdict
// results and drives the registered result channel.
// ----------------------------------------------------------------------------
module afd_back
   import afd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          head_valid,
   input  afd_entry_type head_entry,
   output logic          pop,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [31:0]   rsp_tdata,   // body_byte, body_index, message_kind,
                                      // frame_ok, declared_length, zero pad
   output logic          rsp_tuser,   // out_kind
   output logic          rsp_tlast    // last_result
);

   logic        valid_ff, valid_in;
   logic [31:0] data_ff, data_in;
   logic        kind_ff, kind_in;
   logic        last_ff, last_in;
   logic        body_done_ff, body_done_in;   // body half of the head already sent
   logic        out_free, load, send_body;

   assign out_free  = ~valid_ff | rsp_tready;
   assign load      = out_free & head_valid;
   assign send_body = head_entry.body_valid & ~body_done_ff;

   always_comb begin
      valid_in     = valid_ff & ~rsp_tready;
      data_in      = data_ff;
      kind_in      = kind_ff;
      last_in      = last_ff;
      body_done_in = body_done_ff;
      pop          = 1'b0;
      if (load) begin
         valid_in = 1'b1;
         if (send_body) begin
            data_in = {2'b00, head_entry.declared_length, 1'b0,
                       head_entry.message_kind, head_entry.body_index,
                       head_entry.body_byte};
            kind_in = OUT_BODY;
            last_in = ~head_entry.verdict_valid;
            if (head_entry.verdict_valid) begin
               body_done_in = 1'b1;
            end else begin
               pop = 1'b1;
            end
         end else begin
            data_in = {2'b00, head_entry.declared_length, head_entry.frame_ok,
                       head_entry.message_kind, {INDEX_W{1'b0}}, 8'h00};
            kind_in      = OUT_VERDICT;
            last_in      = 1'b1;
            body_done_in = 1'b0;
            pop          = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= 1'b0;
         body_done_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         body_done_ff <= body_done_in;
      end
      data_ff <= data_in;
      kind_ff <= kind_in;
      last_ff <= last_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = kind_ff;
   assign rsp_tlast  = last_ff;

endmodule
